[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request and result
// payloads, request kinds, and the control group of the row map.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry of the character store.
    localparam int DEF_COLS = 128;
    localparam int DEF_ROWS = 32;

    // Field widths of the channel payloads.
    localparam int KIND_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int IN_COL_W     = 8;
    localparam int IN_ROW_W     = 6;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHAR_W-1:0]   char_code;
        logic [IN_COL_W-1:0] col;
        logic [IN_ROW_W-1:0] row;
    } tcw_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0]       cell_char;
        logic [CURSOR_COL_W-1:0] cursor_col;
        logic [CURSOR_ROW_W-1:0] cursor_row;
    } tcw_out_t;

    // Control group from the sequencer to the row map.
    typedef struct packed {
        logic scroll;     // retire the top row and reuse it as the new bottom row
        logic clear_all;  // invalidate every row and reset the ring offset
        logic set_valid;  // mark the addressed row as holding real data
    } tcw_map_cmd_t;

endpackage

[hw/rtl/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tcw_rowmap.sv]
// ----------------------------------------------------------------------------
// tcw_rowmap
// Maps logical screen rows onto physical memory rows through a ring offset,
// and keeps one valid bit per physical row so that scroll and clear need only
// update the offset and the valid bits.
// ----------------------------------------------------------------------------
module tcw_rowmap
    import tcw_pkg::*;
#(
    parameter int ROWS = DEF_ROWS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tcw_map_cmd_t            cmd,
    input  logic [$clog2(ROWS)-1:0] lrow,
    output logic [$clog2(ROWS)-1:0] prow,
    output logic                    prow_valid
);

    localparam int RW = $clog2(ROWS);

    logic [RW-1:0]   top_reg;
    logic [RW-1:0]   top_next;
    logic [ROWS-1:0] valid_reg;
    logic [ROWS-1:0] valid_next;
    logic [RW:0]     row_sum;

    // Logical to physical row: add the ring offset modulo ROWS.
    always_comb begin
        row_sum = (RW+1)'(lrow) + (RW+1)'(top_reg);
        if (row_sum >= (RW+1)'(ROWS)) begin
            row_sum = row_sum - (RW+1)'(ROWS);
        end
        prow       = row_sum[RW-1:0];
        prow_valid = valid_reg[prow];
    end

    // Ring offset and row valid bits.
    always_comb begin
        top_next   = top_reg;
        valid_next = valid_reg;
        priority if (cmd.clear_all) begin
            top_next   = '0;
            valid_next = '0;
        end else if (cmd.scroll) begin
            // The old top row becomes the new bottom row and reads as blank.
            valid_next[top_reg] = 1'b0;
            top_next = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
        end else if (cmd.set_valid) begin
            valid_next[prow] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg   <= '0;
            valid_reg <= '0;
        end else begin
            top_reg   <= top_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[hw/rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with cursor, line wrap and scroll.
// ----------------------------------------------------------------------------
// Each request puts a character, moves the cursor, clears the screen or reads
// one cell, and returns exactly one result with the cell byte (reads only)
// and the cursor after the request. An accepted request passes through an
// execute state, a read-wait state for a read of a row that holds data, and
// a result state that loads the result; the next request can be accepted
// once the result is loaded. The store is one memory with a single write
// port, so the first character stored into a blank row (after reset, clear
// or scroll) first zero-fills that row in a sweep state. Scroll and clear
// only update the row map, since rows are mapped through a ring offset with
// a valid bit per row; no clearing pass runs after reset. A finished result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tcw_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tcw_out_t m_data
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]        state_reg,   state_next;
    logic [KIND_W-1:0] kind_reg,    kind_next;
    logic [CHAR_W-1:0] char_reg,    char_next;
    logic [CW-1:0]     req_col_reg, req_col_next;
    logic [RW-1:0]     req_row_reg, req_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     sweep_reg,   sweep_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic              m_valid_reg, m_valid_next;
    tcw_out_t          m_data_reg,  m_data_next;

    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;

    tcw_map_cmd_t      map_cmd;
    logic [RW-1:0]     map_lrow;
    logic [RW-1:0]     map_prow;
    logic              map_prow_valid;

    logic [CW:0]       col_inc;
    logic              in_accept;

    // Linear memory address of a cell in a physical row.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] c);
        return AW'(prow) * AW'(COLS) + AW'(c);
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Reads address the requested row, every other kind the cursor row.
    assign map_lrow = (kind_reg == KIND_READ) ? req_row_reg : cur_row_reg;
    assign col_inc  = (CW+1)'(cur_col_reg) + (CW+1)'(1);

    // Sequencer: capture, execute against the store, and hand over the result.
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        char_next     = char_reg;
        req_col_next  = req_col_reg;
        req_row_next  = req_row_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        sweep_next    = sweep_reg;
        res_char_next = res_char_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = cell_addr(map_prow, cur_col_reg);
        mem_raddr     = cell_addr(map_prow, req_col_reg);
        mem_wdata     = char_reg;
        map_cmd       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_next     = s_data.kind;
                    char_next     = s_data.char_code;
                    req_col_next  = (9'(s_data.col) > 9'(COLS - 1))
                                    ? CW'(COLS - 1) : CW'(s_data.col);
                    req_row_next  = (7'(s_data.row) > 7'(ROWS - 1))
                                    ? RW'(ROWS - 1) : RW'(s_data.row);
                    res_char_next = '0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_RESULT;
                unique case (kind_reg)
                    KIND_PUT: begin
                        if (char_reg == NUL_CODE) begin
                            state_next = ST_RESULT;
                        end else if (char_reg == NEWLINE_CODE) begin
                            cur_col_next = '0;
                            if (cur_row_reg == RW'(ROWS - 1)) begin
                                map_cmd.scroll = 1'b1;
                            end else begin
                                cur_row_next = cur_row_reg + RW'(1);
                            end
                        end else if (!map_prow_valid) begin
                            // Blank row: zero-fill it before the first write.
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end else begin
                            mem_we = 1'b1;
                            if (col_inc == (CW+1)'(COLS)) begin
                                cur_col_next = '0;
                                if (cur_row_reg == RW'(ROWS - 1)) begin
                                    map_cmd.scroll = 1'b1;
                                end else begin
                                    cur_row_next = cur_row_reg + RW'(1);
                                end
                            end else begin
                                cur_col_next = col_inc[CW-1:0];
                            end
                        end
                    end
                    KIND_MOVE: begin
                        cur_col_next = req_col_reg;
                        cur_row_next = req_row_reg;
                    end
                    KIND_CLEAR: begin
                        map_cmd.clear_all = 1'b1;
                        cur_col_next      = '0;
                        cur_row_next      = '0;
                    end
                    KIND_READ: begin
                        // A blank row reads as zero without a memory access.
                        if (map_prow_valid) begin
                            mem_re     = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(map_prow, sweep_reg);
                mem_wdata = '0;
                if (sweep_reg == CW'(COLS - 1)) begin
                    map_cmd.set_valid = 1'b1;
                    state_next        = ST_EXEC;
                end else begin
                    sweep_next = sweep_reg + CW'(1);
                end
            end

            ST_RDWAIT: begin
                res_char_next = mem_rdata;
                state_next    = ST_RESULT;
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cell_char  = res_char_reg;
                    m_data_next.cursor_col = CURSOR_COL_W'(cur_col_reg);
                    m_data_next.cursor_row = CURSOR_ROW_W'(cur_row_reg);
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        char_reg     <= char_next;
        req_col_reg  <= req_col_next;
        req_row_reg  <= req_row_next;
        sweep_reg    <= sweep_next;
        res_char_reg <= res_char_next;
        m_data_reg   <= m_data_next;
    end

    tcw_rowmap #(
        .ROWS(ROWS)
    ) u_rowmap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (map_cmd),
        .lrow      (map_lrow),
        .prow      (map_prow),
        .prow_valid(map_prow_valid)
    );

    tcw_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

`ifndef SYNTHESIS
    // The store is never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("store read and write in the same cycle");

    // Read data is taken only in the cycle after a read was issued.
    a_rdwait_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDWAIT) |-> $past(mem_re))
        else $error("read data taken without a preceding read");

    // The cursor stays inside the screen.
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg <= CW'(COLS - 1)) && (cur_row_reg <= RW'(ROWS - 1)))
        else $error("cursor outside the screen");

    // An accepted request blocks the input until its result is handed over.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("second request accepted while one is in flight");

    // Zero-filling only happens for a put into a blank row.
    a_sweep_for_put: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (kind_reg == KIND_PUT) && !map_prow_valid)
        else $error("row fill outside a put into a blank row");
`endif

endmodule

[verif/text_console_writer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer.
// ----------------------------------------------------------------------------
// A host-side copy of the console (character store plus cursor) predicts the
// result of every accepted request. A checker process compares each result,
// field by field, with the oldest prediction. A short directed part covers
// reset contents, printing, newlines, the zero byte, line wrap, scroll,
// clamped moves and reads, and clear. A random part then sends mostly printable
// strings ended by a zero byte, scrolling and wrapping lines, reads close to
// the text, moves, clears and raw noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
    import tcw_pkg::*;

    localparam int COLS         = DEF_COLS;
    localparam int ROWS         = DEF_ROWS;
    localparam int MAX_GAP      = 14;
    localparam int RANDOM_GOAL  = 650;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tcw_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tcw_out_t m_data;

    // Host-side copy of the console.
    logic [CHAR_W-1:0] screen [ROWS][COLS];
    int unsigned       cursor_x = 0;
    int unsigned       cursor_y = 0;

    // Results still owed by the block, oldest first.
    tcw_out_t console_results_due [$];

    // Run statistics.
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned live_requests  = 0;
    int unsigned results_seen   = 0;
    int unsigned wrap_count     = 0;
    int unsigned scroll_count   = 0;
    int unsigned text_reads     = 0;

    // Idle-free stretches for the request and result sides.
    bit quiet_input  = 1'b0;
    bit quiet_output = 1'b0;

    text_console_writer_top #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a correct run finishes far below this bound.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results due", cycle_count,
                     console_results_due.size());
            $display("text_console_writer_top_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH (cycle %0d): %s", cycle_count, what);
        end
    endtask

    // Zero the whole store and home the cursor.
    function automatic void wipe_screen();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                screen[r][c] = '0;
            end
        end
        cursor_x = 0;
        cursor_y = 0;
    endfunction

    // Go to column 0 of the next row, scrolling up when already on the last row.
    function automatic void advance_line();
        cursor_x = 0;
        if (cursor_y + 1 >= ROWS) begin
            cursor_y = ROWS - 1;
            scroll_count++;
            for (int r = 0; r < ROWS - 1; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    screen[r][c] = screen[r + 1][c];
                end
            end
            for (int c = 0; c < COLS; c++) begin
                screen[ROWS - 1][c] = '0;
            end
        end else begin
            cursor_y++;
        end
    endfunction

    // Apply one request to the host copy and return the result it must give.
    function automatic tcw_out_t predict_console(input tcw_in_t req);
        tcw_out_t    res;
        int unsigned c;
        int unsigned r;
        c   = (req.col > COLS - 1) ? COLS - 1 : req.col;
        r   = (req.row > ROWS - 1) ? ROWS - 1 : req.row;
        res = '0;
        case (req.kind)
            KIND_PUT: begin
                if (req.char_code == NEWLINE_CODE) begin
                    advance_line();
                end else if (req.char_code != NUL_CODE) begin
                    screen[cursor_y][cursor_x] = req.char_code;
                    cursor_x++;
                    if (cursor_x >= COLS) begin
                        wrap_count++;
                        advance_line();
                    end
                end
            end
            KIND_MOVE: begin
                cursor_x = c;
                cursor_y = r;
            end
            KIND_CLEAR: begin
                wipe_screen();
            end
            KIND_READ: begin
                res.cell_char = screen[r][c];
                if (res.cell_char != NUL_CODE) begin
                    text_reads++;
                end
            end
            default: begin
            end
        endcase
        res.cursor_col = cursor_x[CURSOR_COL_W-1:0];
        res.cursor_row = cursor_y[CURSOR_ROW_W-1:0];
        return res;
    endfunction

    function automatic tcw_in_t make_request(input int unsigned kind, input int unsigned ch,
                                             input int unsigned col, input int unsigned row);
        tcw_in_t req;
        req.kind      = kind[KIND_W-1:0];
        req.char_code = ch[CHAR_W-1:0];
        req.col       = col[IN_COL_W-1:0];
        req.row       = row[IN_ROW_W-1:0];
        return req;
    endfunction

    // Send one request. Valid is lowered only when a gap is drawn, so a
    // back-to-back request keeps valid high through the step.
    task automatic send_request(input tcw_in_t req);
        int unsigned gap;
        gap = quiet_input ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        console_results_due.push_back(predict_console(req));
        requests_sent++;
        if (!(req.kind == KIND_PUT && req.char_code == NUL_CODE)) begin
            live_requests++;
        end
    endtask

    // Put a character; the column and row fields carry noise.
    task automatic send_char(input int unsigned ch);
        send_request(make_request(KIND_PUT, ch, $urandom_range(0, 255), $urandom_range(0, 63)));
    endtask

    // Hold off new requests until every owed result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (console_results_due.size() != 0) @(posedge aclk);
    endtask

    // A host string: characters, then the zero byte that ends it.
    task automatic send_string(input int unsigned len, input bit any_byte);
        int unsigned ch;
        for (int i = 0; i < len; i++) begin
            if (any_byte) begin
                ch = $urandom_range(1, 255);
            end else if ($urandom_range(0, 9) == 0) begin
                ch = NEWLINE_CODE;
            end else begin
                ch = $urandom_range(32, 126);
            end
            send_char(ch);
        end
        send_char(NUL_CODE);
    endtask

    // Result side: random stall, then accept and check one result.
    initial begin : result_checker
        tcw_out_t    want;
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = quiet_output ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (console_results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
            end else begin
                want = console_results_due.pop_front();
                if (m_data.cell_char !== want.cell_char) begin
                    report_mismatch($sformatf("result %0d cell_char %h, want %h",
                                              results_seen, m_data.cell_char, want.cell_char));
                end
                if (m_data.cursor_col !== want.cursor_col) begin
                    report_mismatch($sformatf("result %0d cursor_col %0d, want %0d",
                                              results_seen, m_data.cursor_col, want.cursor_col));
                end
                if (m_data.cursor_row !== want.cursor_row) begin
                    report_mismatch($sformatf("result %0d cursor_row %0d, want %0d",
                                              results_seen, m_data.cursor_row, want.cursor_row));
                end
            end
        end
    end

    // The store reads back as zero after reset, also at clamped coordinates.
    task automatic test_reset_contents();
        send_request(make_request(KIND_READ, 0, 0, 0));
        send_request(make_request(KIND_READ, 0, 255, 63));
    endtask

    // Printing, the largest byte, the ignored zero byte and newline.
    task automatic test_put_newline();
        send_char("A");
        send_char(255);
        send_char(NUL_CODE);
        send_char(NEWLINE_CODE);
        send_char(1);
        send_request(make_request(KIND_READ, 0, 1, 0));
    endtask

    // Moves past the store clamp to the last cell; a character there wraps
    // and scrolls at once.
    task automatic test_move_clamp_scroll();
        send_request(make_request(KIND_MOVE, 0, 255, 63));
        send_char("Z");
        send_request(make_request(KIND_READ, 0, COLS - 1, ROWS - 2));
        send_request(make_request(KIND_MOVE, 0, COLS, ROWS));
        send_request(make_request(KIND_MOVE, 0, 0, ROWS - 1));
        send_char(NEWLINE_CODE);
        send_request(make_request(KIND_READ, 0, 0, 0));
    endtask

    // Wrap in the middle of the screen.
    task automatic test_line_wrap();
        send_request(make_request(KIND_MOVE, 0, COLS - 2, 5));
        send_char("x");
        send_char("y");
        send_request(make_request(KIND_READ, 0, COLS - 2, 5));
        send_request(make_request(KIND_READ, 0, COLS - 1, 5));
    endtask

    // Clear zeros everything and homes the cursor.
    task automatic test_clear();
        send_request(make_request(KIND_CLEAR, 0, 200, 40));
        send_request(make_request(KIND_READ, 0, COLS - 1, ROWS - 2));
    endtask

    // Mostly well-formed host traffic with random content, plus noise.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned pick;
        int unsigned lo_row;
        bit          paused;
        goal   = live_requests + RANDOM_GOAL;
        paused = 1'b0;
        while (live_requests < goal) begin
            quiet_input  = ($urandom_range(0, 5) == 0);
            quiet_output = ($urandom_range(0, 5) == 0);
            pick         = $urandom_range(0, 99);
            if (pick < 35) begin
                send_string($urandom_range(1, 24), $urandom_range(0, 3) == 0);
            end else if (pick < 48) begin
                // Text on the last row, so newlines scroll.
                send_request(make_request(KIND_MOVE, 0, $urandom_range(0, COLS - 1), ROWS - 1));
                send_string($urandom_range(1, 16), 1'b0);
            end else if (pick < 60) begin
                // Start close to the right edge so the line wraps.
                send_request(make_request(KIND_MOVE, 0, COLS - 1 - $urandom_range(0, 15),
                                          $urandom_range(0, 63)));
                send_string($urandom_range(8, 30), 1'b0);
            end else if (pick < 80) begin
                // Reads around the cursor, where the text is.
                lo_row = (cursor_y > 0) ? cursor_y - 1 : 0;
                repeat ($urandom_range(1, 6)) begin
                    send_request(make_request(KIND_READ, $urandom_range(0, 255),
                                              ($urandom_range(0, 3) == 0) ?
                                                  $urandom_range(0, 255) :
                                                  $urandom_range(0, COLS - 1),
                                              ($urandom_range(0, 3) == 0) ?
                                                  $urandom_range(0, 63) :
                                                  $urandom_range(lo_row, cursor_y)));
                end
            end else if (pick < 88) begin
                send_request(make_request(KIND_MOVE, $urandom_range(0, 255),
                                          $urandom_range(0, 255), $urandom_range(0, 63)));
            end else if (pick < 90) begin
                send_request(make_request(KIND_CLEAR, $urandom_range(0, 255),
                                          $urandom_range(0, 255), $urandom_range(0, 63)));
            end else begin
                send_request(make_request($urandom_range(0, 3), $urandom_range(0, 255),
                                          $urandom_range(0, 255), $urandom_range(0, 63)));
            end
            if (!paused && live_requests >= goal - RANDOM_GOAL / 2) begin
                paused = 1'b1;
                wait_for_results();
            end
        end
    endtask

    // Reset, then the tests in turn, then the drain and the verdict.
    initial begin
        wipe_screen();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_contents();
        test_put_newline();
        test_move_clamp_scroll();
        test_line_wrap();
        test_clear();
        test_random_traffic();

        wait_for_results();
        repeat (COLS + 16) @(posedge aclk);

        $display("Sent %0d requests (%0d doing work), checked %0d results.",
                 requests_sent, live_requests, results_seen);
        $display("Saw %0d line wraps, %0d scrolls and %0d reads of nonzero cells.",
                 wrap_count, scroll_count, text_reads);
        if (mismatch_count == 0) begin
            $display("text_console_writer_top_tb OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("text_console_writer_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[text_console_writer_top.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_rowmap.sv
hw/rtl/text_console_writer_top.sv
verif/text_console_writer_top_tb.sv
